// ===== design/igfc_pkg.sv =====
// ----------------------------------------------------------------------------
// igfc_pkg
// Shared constants, types and elaboration-time table builders for the
// intensity gamma / false-color mapper.
// ----------------------------------------------------------------------------
package igfc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 11;
    localparam int LOG_W     = FRAC_BITS + 4;
    localparam int ENA_W     = 12;
    localparam int P_W       = LOG_W + ENA_W;
    localparam int Q_W       = P_W - 8;
    localparam int RSH       = P_W + 9;
    localparam int R_W       = P_W + 1;
    localparam int EXP_DIV   = 300;
    localparam longint unsigned RECIP = (64'd1 << RSH) / EXP_DIV;
    localparam logic [FRAC_BITS:0] ONEQ = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    localparam logic [2:0] PAL_RAINBOW  = 3'd0;
    localparam logic [2:0] PAL_LBLUE    = 3'd1;
    localparam logic [2:0] PAL_GRAY     = 3'd2;
    localparam logic [2:0] PAL_COOLHOT  = 3'd3;
    localparam logic [2:0] PAL_PHOSPHOR = 3'd4;

    typedef enum logic [1:0] {
        CFG_SENS     = 2'd0,
        CFG_CONTRAST = 2'd1,
        CFG_PALETTE  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic       zero;
        logic       one;
        logic [7:0] tag;
    } t_side;

    typedef logic [255:0][23:0] t_lut;

    function automatic longint unsigned isqrt_f(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned xx;
        res  = 0;
        bitv = 64'd1 << 62;
        xx   = x;
        while (bitv > xx) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (xx >= res + bitv) begin
                xx  = xx - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned log2q_f(int x);
        int k;
        longint unsigned m;
        longint unsigned res;
        k = 0;
        while (k < 31 && (x >> (k + 1)) != 0) k++;
        m   = (longint'(x) << FRAC_BITS) >> k;
        res = longint'(k) << FRAC_BITS;
        for (int i = 1; i <= FRAC_BITS; i++) begin
            m = (m * m) >> FRAC_BITS;
            if (m >= (64'd2 << FRAC_BITS)) begin
                m   = m >> 1;
                res = res | (64'd1 << (FRAC_BITS - i));
            end
        end
        return res;
    endfunction

    // root 2^(-2^-i) in Q.FRAC_BITS
    function automatic longint unsigned root_f(int i);
        longint unsigned c;
        c = isqrt_f(64'd1 << (2 * FRAC_BITS - 1));
        for (int j = 1; j < i; j++) c = isqrt_f(c << FRAC_BITS);
        return c;
    endfunction

    function automatic int sat8_f(longint v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return int'(v);
    endfunction

    // quotient by repeated subtraction; the result never exceeds 255
    function automatic int lerp_f(int s, int e, longint num, longint den);
        longint total;
        longint q;
        total = longint'(s) * den + longint'(e - s) * num;
        if (total < 0) total = 0;
        q = 0;
        while (total >= den) begin
            total = total - den;
            q     = q + 1;
        end
        return sat8_f(q);
    endfunction

    function automatic logic [23:0] pal_f(int sel, int v);
        int r, g, b, u, s;
        int sp [5];
        int sc [5][3];
        sp = '{0, 35, 65, 85, 100};
        sc = '{'{6, 18, 6}, '{18, 78, 18}, '{32, 190, 32},
               '{140, 255, 140}, '{228, 255, 196}};
        r = 0; g = 0; b = 0;
        case (sel)
            0: begin
                if (v <= 63) begin
                    b = sat8_f(4 * v);
                end else if (v <= 127) begin
                    u = 4 * v - 255;
                    g = sat8_f(u);
                    b = sat8_f((65025 - 105 * u) / 255);
                end else if (v <= 191) begin
                    u = 4 * v - 510;
                    r = sat8_f(u); g = 255; b = sat8_f(150 * (255 - u) / 255);
                end else begin
                    u = 4 * v - 765;
                    r = 255; g = sat8_f(255 - u);
                end
            end
            1: begin
                if (v <= 84) begin
                    b = sat8_f(450 * v / 255);
                end else if (v <= 168) begin
                    u = 300 * v - 25245;
                    g = sat8_f(206 * longint'(u) / 25500);
                    b = sat8_f(150 + 105 * longint'(u) / 25500);
                end else begin
                    u = 300 * v - 50490;
                    r = sat8_f(u / 100);
                    g = sat8_f(206 + 49 * longint'(u) / 25500);
                    b = 255;
                end
            end
            3: begin
                if (v <= 63) begin
                    r = sat8_f(400 * v / 255); b = sat8_f(600 * v / 255);
                end else if (v <= 127) begin
                    u = 4 * v - 255;
                    r = sat8_f(100 + 155 * u / 255);
                    b = sat8_f(150 * (255 - u) / 255);
                end else if (v <= 191) begin
                    u = 4 * v - 510;
                    r = 255; g = sat8_f(200 * u / 255);
                end else begin
                    u = 4 * v - 765;
                    r = 255; g = sat8_f(200 + 55 * u / 255); b = sat8_f(u);
                end
            end
            default: begin
                if (v <= 0) begin
                    r = sc[0][0]; g = sc[0][1]; b = sc[0][2];
                end else if (v >= 255) begin
                    r = sc[4][0]; g = sc[4][1]; b = sc[4][2];
                end else begin
                    s = 0;
                    while (s < 3 && 100 * v > 255 * sp[s + 1]) s++;
                    r = lerp_f(sc[s][0], sc[s + 1][0], 100 * v - 255 * sp[s],
                               255 * (sp[s + 1] - sp[s]));
                    g = lerp_f(sc[s][1], sc[s + 1][1], 100 * v - 255 * sp[s],
                               255 * (sp[s + 1] - sp[s]));
                    b = lerp_f(sc[s][2], sc[s + 1][2], 100 * v - 255 * sp[s],
                               255 * (sp[s + 1] - sp[s]));
                end
            end
        endcase
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    function automatic t_lut build_lut(int sel);
        t_lut lut;
        for (int v = 0; v < 256; v++) lut[v] = pal_f(sel, v);
        return lut;
    endfunction

    // start + (end-start)*t/ONEQ with end <= start, truncated
    function automatic logic [7:0] lcd_ch(logic [7:0] s, logic [7:0] e,
                                          logic [FRAC_BITS:0] t);
        logic [FRAC_BITS+8:0] tot;
        tot = ((FRAC_BITS + 9)'(s) << FRAC_BITS) - (FRAC_BITS + 9)'(s - e) * t;
        return tot[FRAC_BITS+7:FRAC_BITS];
    endfunction

endpackage

// ===== design/igfc_powq.sv =====
// ----------------------------------------------------------------------------
// igfc_powq
// Pipelined fractional power (num/den)^(ena/300) in Q.FRAC_BITS via
// log2 by repeated squaring, constant divide, and exp2 by a root chain.
// ----------------------------------------------------------------------------
module igfc_powq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [igfc_pkg::NUM_W-1:0]    i_num,
    input  logic [igfc_pkg::NUM_W-1:0]    i_den,
    input  logic [igfc_pkg::LOG_W-1:0]    i_ld,
    input  logic [igfc_pkg::ENA_W-1:0]    i_ena,
    input  logic [7:0]                    i_tag,
    output logic                          o_valid,
    output logic [igfc_pkg::FRAC_BITS:0]  o_pow,
    output logic [7:0]                    o_tag
);
    localparam int FB = igfc_pkg::FRAC_BITS;

    logic                          r_vl  [0:FB];
    igfc_pkg::t_side               r_sdl [0:FB];
    logic [FB:0]                   r_m   [0:FB];
    logic [igfc_pkg::LOG_W-1:0]    r_ln  [0:FB];
    logic [igfc_pkg::LOG_W-1:0]    r_ld  [0:FB];
    logic [igfc_pkg::ENA_W-1:0]    r_ena [0:FB];

    logic [3:0]                    k;
    logic [igfc_pkg::NUM_W+FB-1:0] m_sh;

    always_comb begin
        k = '0;
        for (int b = 0; b < igfc_pkg::NUM_W; b++) begin
            if (i_num[b]) k = 4'(b);
        end
        m_sh = {i_num, FB'(0)} >> k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl[0] <= 1'b0;
        end else if (i_en) begin
            r_vl[0] <= i_valid;
        end
        if (i_en) begin
            r_sdl[0] <= '{zero: (i_num == '0), one: (i_num >= i_den), tag: i_tag};
            r_m[0]   <= m_sh[FB:0];
            r_ln[0]  <= {k, FB'(0)};
            r_ld[0]  <= i_ld;
            r_ena[0] <= i_ena;
        end
    end

    // log2 fraction: one squaring per stage
    for (genvar i = 1; i <= FB; i++) begin : g_log
        logic [2*FB+1:0] sq;
        logic [FB+1:0]   ms;
        logic [FB:0]     n_m;
        logic [igfc_pkg::LOG_W-1:0] n_ln;
        always_comb begin
            sq   = r_m[i-1] * r_m[i-1];
            ms   = sq[2*FB+1:FB];
            n_ln = r_ln[i-1];
            if (ms[FB+1]) begin
                n_m = ms[FB+1:1];
                n_ln[FB-i] = 1'b1;
            end else begin
                n_m = ms[FB:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vl[i] <= 1'b0;
            end else if (i_en) begin
                r_vl[i] <= r_vl[i-1];
            end
            if (i_en) begin
                r_sdl[i] <= r_sdl[i-1];
                r_m[i]   <= n_m;
                r_ln[i]  <= n_ln;
                r_ld[i]  <= r_ld[i-1];
                r_ena[i] <= r_ena[i-1];
            end
        end
    end

    // exponent product, then divide by 300 via reciprocal
    logic                        r_vd, r_vq1, r_vq2;
    igfc_pkg::t_side             r_sdd, r_sdq1, r_sdq2;
    logic [igfc_pkg::P_W-1:0]    r_p, r_pq1;
    logic [igfc_pkg::Q_W-1:0]    r_qq, r_q2;
    logic [igfc_pkg::LOG_W-1:0]  d;
    logic [igfc_pkg::P_W+igfc_pkg::R_W-1:0] rprod;
    logic [igfc_pkg::P_W-1:0]    rem;

    always_comb begin
        d     = (r_ld[FB] > r_ln[FB]) ? r_ld[FB] - r_ln[FB] : '0;
        rprod = (igfc_pkg::P_W + igfc_pkg::R_W)'(r_p)
              * (igfc_pkg::P_W + igfc_pkg::R_W)'(igfc_pkg::RECIP);
        rem   = r_pq1 - igfc_pkg::P_W'(r_qq) * igfc_pkg::P_W'(igfc_pkg::EXP_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd  <= 1'b0;
            r_vq1 <= 1'b0;
            r_vq2 <= 1'b0;
        end else if (i_en) begin
            r_vd  <= r_vl[FB];
            r_vq1 <= r_vd;
            r_vq2 <= r_vq1;
        end
        if (i_en) begin
            r_sdd  <= r_sdl[FB];
            r_p    <= igfc_pkg::P_W'(d) * igfc_pkg::P_W'(r_ena[FB]);
            r_sdq1 <= r_sdd;
            r_pq1  <= r_p;
            r_qq   <= rprod[igfc_pkg::RSH+igfc_pkg::Q_W-1:igfc_pkg::RSH];
            r_sdq2 <= r_sdq1;
            r_q2   <= (rem >= igfc_pkg::P_W'(igfc_pkg::EXP_DIV)) ? r_qq + 1'b1 : r_qq;
        end
    end

    // exp2 of the negative fraction: one root multiply per stage
    logic                     r_ve [0:FB];
    igfc_pkg::t_side          r_sde[0:FB];
    logic [FB:0]              r_r  [0:FB];
    logic [igfc_pkg::Q_W-1:0] r_q  [0:FB];

    always_comb begin
        r_ve[0]  = r_vq2;
        r_sde[0] = r_sdq2;
        r_r[0]   = igfc_pkg::ONEQ;
        r_q[0]   = r_q2;
    end

    for (genvar i = 1; i <= FB; i++) begin : g_exp
        localparam logic [FB:0] ROOT = (FB + 1)'(igfc_pkg::root_f(i));
        logic [2*FB+1:0] pr;
        assign pr = r_r[i-1] * ROOT;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ve[i] <= 1'b0;
            end else if (i_en) begin
                r_ve[i] <= r_ve[i-1];
            end
            if (i_en) begin
                r_sde[i] <= r_sde[i-1];
                r_q[i]   <= r_q[i-1];
                r_r[i]   <= r_q[i-1][FB-i] ? pr[2*FB:FB] : r_r[i-1];
            end
        end
    end

    logic        r_vo;
    logic [FB:0] r_pow;
    logic [7:0]  r_tag;
    logic [igfc_pkg::Q_W-FB-1:0] n_int;
    logic [FB:0] n_pow;

    always_comb begin
        n_int = r_q[FB][igfc_pkg::Q_W-1:FB];
        if (r_sde[FB].zero) begin
            n_pow = '0;
        end else if (r_sde[FB].one) begin
            n_pow = igfc_pkg::ONEQ;
        end else if (n_int < (igfc_pkg::Q_W - FB)'(63)) begin
            n_pow = r_r[FB] >> n_int;
        end else begin
            n_pow = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_ve[FB];
        end
        if (i_en) begin
            r_pow <= n_pow;
            r_tag <= r_sde[FB].tag;
        end
    end

    assign o_valid = r_vo;
    assign o_pow   = r_pow;
    assign o_tag   = r_tag;
endmodule

// ===== design/igfc_palette.sv =====
// ----------------------------------------------------------------------------
// igfc_palette
// Maps the gamma-corrected index to red, green and blue; registered output.
// ----------------------------------------------------------------------------
module igfc_palette (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [7:0]                   i_v,
    input  logic [igfc_pkg::FRAC_BITS:0] i_t,
    input  logic [2:0]                   i_sel,
    output logic                         o_valid,
    output logic [7:0]                   o_red,
    output logic [7:0]                   o_green,
    output logic [7:0]                   o_blue
);
    localparam igfc_pkg::t_lut LUT_RB = igfc_pkg::build_lut(0);
    localparam igfc_pkg::t_lut LUT_LB = igfc_pkg::build_lut(1);
    localparam igfc_pkg::t_lut LUT_CH = igfc_pkg::build_lut(3);
    localparam igfc_pkg::t_lut LUT_PH = igfc_pkg::build_lut(4);

    logic        r_valid;
    logic [23:0] r_rgb;
    logic [23:0] n_rgb;
    logic [7:0]  hi_ch;

    always_comb begin
        hi_ch = igfc_pkg::lcd_ch(8'h38, 8'h00, i_t);
        case (i_sel)
            igfc_pkg::PAL_RAINBOW:  n_rgb = LUT_RB[i_v];
            igfc_pkg::PAL_LBLUE:    n_rgb = LUT_LB[i_v];
            igfc_pkg::PAL_GRAY:     n_rgb = {i_v, i_v, i_v};
            igfc_pkg::PAL_COOLHOT:  n_rgb = LUT_CH[i_v];
            igfc_pkg::PAL_PHOSPHOR: n_rgb = LUT_PH[i_v];
            default: begin
                if (i_v <= 8'd114) begin
                    n_rgb = {igfc_pkg::lcd_ch(8'h79, 8'h38, i_t),
                             igfc_pkg::lcd_ch(8'h9A, 8'h38, i_t),
                             igfc_pkg::lcd_ch(8'hA4, 8'h38, i_t)};
                end else begin
                    n_rgb = {hi_ch, hi_ch, hi_ch};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_rgb[23:16];
    assign o_green = r_rgb[15:8];
    assign o_blue  = r_rgb[7:0];
endmodule

// ===== design/intensity_gamma_false_color_map.sv =====
// Registered path: offset, gamma power unit, index, lcd power unit, palette.
// Throughput: one word per cycle unless stalled; power units fully pipelined.
// A stalled output freezes the whole pipeline, bubbles included.
// Reset (synchronous, active low) clears all valid bits and loads
// sensitivity 100, contrast 100, palette rainbow.
// ----------------------------------------------------------------------------
// intensity_gamma_false_color_map
// Offset, gamma correction and false-color palette mapping of pixel intensity.
// ----------------------------------------------------------------------------
module intensity_gamma_false_color_map (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_intensity,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    localparam int FB = igfc_pkg::FRAC_BITS;
    localparam logic [igfc_pkg::LOG_W-1:0] LD_1275 = igfc_pkg::LOG_W'(igfc_pkg::log2q_f(1275));
    localparam logic [igfc_pkg::LOG_W-1:0] LD_459  = igfc_pkg::LOG_W'(igfc_pkg::log2q_f(459));
    localparam logic [igfc_pkg::LOG_W-1:0] LD_561  = igfc_pkg::LOG_W'(igfc_pkg::log2q_f(561));

    logic [7:0] r_sens;
    logic [8:0] r_contrast;
    logic [2:0] r_pal;
    logic       en;

    assign o_cfg_ready = 1'b1;
    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens     <= 8'd100;
            r_contrast <= 9'd100;
            r_pal      <= igfc_pkg::PAL_RAINBOW;
        end else if (i_cfg_valid) begin
            case (igfc_pkg::t_cfg_idx'(i_cfg_index))
                igfc_pkg::CFG_SENS:     r_sens     <= i_cfg_data[7:0];
                igfc_pkg::CFG_CONTRAST: r_contrast <= i_cfg_data;
                igfc_pkg::CFG_PALETTE:  r_pal      <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // offset in fifths: 5*intensity + 4*(sensitivity-100), clamped to 0..1275
    logic        r_xv;
    logic [10:0] r_x5;
    logic [12:0] sum;
    logic [10:0] n_x5;

    always_comb begin
        sum = 13'(i_intensity) * 13'd5 + 13'(r_sens) * 13'd4;
        if (sum < 13'd400) begin
            n_x5 = '0;
        end else if (sum > 13'd1675) begin
            n_x5 = 11'd1275;
        end else begin
            n_x5 = 11'(sum - 13'd400);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv <= 1'b0;
        end else if (en) begin
            r_xv <= i_valid;
        end
        if (en) begin
            r_x5 <= n_x5;
        end
    end

    logic        ga_valid;
    logic [FB:0] ga_pow;
    logic [7:0]  ga_tag;

    igfc_powq u_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_xv),
        .i_num   (r_x5),
        .i_den   (11'd1275),
        .i_ld    (LD_1275),
        .i_ena   (igfc_pkg::ENA_W'(12'd150 + 12'(r_contrast) * 12'd4)),
        .i_tag   (8'd0),
        .o_valid (ga_valid),
        .o_pow   (ga_pow),
        .o_tag   (ga_tag)
    );

    // index v = 255*t >> FRAC_BITS
    logic            r_vv;
    logic [7:0]      r_v;
    logic [FB+8:0]   scaled;
    logic            lo;
    logic [10:0]     lnum;

    assign scaled = (FB + 9)'(ga_pow) * (FB + 9)'(255);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv <= 1'b0;
        end else if (en) begin
            r_vv <= ga_valid;
        end
        if (en) begin
            r_v <= scaled[FB+7:FB] | ga_tag;
        end
    end

    assign lo   = (r_v <= 8'd114);
    assign lnum = lo ? {r_v, 2'b00} : 11'({r_v, 2'b00} - 11'd459);

    logic        lc_valid;
    logic [FB:0] lc_pow;
    logic [7:0]  lc_v;

    igfc_powq u_lcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vv),
        .i_num   (lnum),
        .i_den   (lo ? 11'd459 : 11'd561),
        .i_ld    (lo ? LD_459 : LD_561),
        .i_ena   (lo ? 12'd225 : 12'd210),
        .i_tag   (r_v),
        .o_valid (lc_valid),
        .o_pow   (lc_pow),
        .o_tag   (lc_v)
    );

    igfc_palette u_pal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (lc_valid),
        .i_v     (lc_v),
        .i_t     (lc_pow),
        .i_sel   (r_pal),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );
endmodule

// ===== sim/igfc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfc_checker
// Watches the pixel, color and register channels of the intensity mapper,
// predicts each color word from the intensity and the current registers,
// and compares it field by field against the words the block sends.
// ----------------------------------------------------------------------------
module igfc_checker
    import igfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_px_valid,
    input  logic       i_px_stall,
    input  logic [7:0] i_px_intensity,
    input  logic       i_col_valid,
    input  logic       i_col_stall,
    input  logic [7:0] i_col_red,
    input  logic [7:0] i_col_green,
    input  logic [7:0] i_col_blue,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int FB = FRAC_BITS;
    localparam longint unsigned UNIT = 64'd1 << FB;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    logic [7:0] sens_q;
    logic [8:0] contrast_q;
    logic [2:0] palette_q;
    t_color     color_q [$];

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned acc, probe, rem;
        acc   = 0;
        probe = 64'd1 << 62;
        rem   = x;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= acc + probe) begin
                rem = rem - (acc + probe);
                acc = (acc >> 1) + probe;
            end else begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        return acc;
    endfunction

    function automatic longint unsigned log2_fix(int unsigned x);
        int unsigned msb;
        longint unsigned mant, acc;
        msb = 0;
        while (msb < 31 && (x >> (msb + 1)) != 0) msb++;
        mant = (longint'(x) << FB) >> msb;
        acc  = longint'(msb) << FB;
        for (int i = 1; i <= FB; i++) begin
            mant = (mant * mant) >> FB;
            if (mant >= (UNIT << 1)) begin
                mant = mant >> 1;
                acc  = acc | (64'd1 << (FB - i));
            end
        end
        return acc;
    endfunction

    // (num/den)^(en/ed) as exp2(-e*log2(den/num)), Q.FB
    function automatic longint unsigned ratio_pow(int unsigned num, int unsigned den,
                                                  int unsigned en, int unsigned ed);
        longint unsigned lnum, lden, diff, prod, ipart, fpart, acc, root;
        if (num == 0) return 0;
        if (num >= den) return UNIT;
        lnum  = log2_fix(num);
        lden  = log2_fix(den);
        diff  = lden > lnum ? lden - lnum : 0;
        prod  = diff * en / ed;
        ipart = prod >> FB;
        fpart = prod & (UNIT - 1);
        acc   = UNIT;
        root  = int_sqrt(64'd1 << (2 * FB - 1));
        for (int i = 1; i <= FB; i++) begin
            if ((fpart >> (FB - i)) & 1) acc = (acc * root) >> FB;
            root = int_sqrt(root << FB);
        end
        return ipart < 63 ? acc >> ipart : 0;
    endfunction

    function automatic logic [7:0] clip8(longint v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return 8'(v);
    endfunction

    function automatic logic [7:0] blend(longint s, longint e, longint num, longint den);
        longint total;
        total = s * den + (e - s) * num;
        if (total < 0) total = 0;
        return clip8(total / den);
    endfunction

    function automatic t_color map_pixel(logic [7:0] inten, logic [7:0] sens,
                                         logic [8:0] ctr, logic [2:0] pal);
        longint x5, v, u, t, num, den;
        longint stop_at [5];
        longint stop_rgb [5][3];
        longint lcd_base [3];
        longint ch [3];
        int seg;
        t_color c;
        stop_at  = '{0, 35, 65, 85, 100};
        stop_rgb = '{'{6, 18, 6}, '{18, 78, 18}, '{32, 190, 32},
                     '{140, 255, 140}, '{228, 255, 196}};
        lcd_base = '{8'h79, 8'h9A, 8'hA4};
        x5 = 5 * longint'(inten) + 4 * (longint'(sens) - 100);
        if (x5 < 0) x5 = 0;
        if (x5 > 1275) x5 = 1275;
        v = (255 * ratio_pow(x5, 1275, 75 + 2 * ctr, 150)) >> FB;
        if (v > 255) v = 255;
        ch = '{0, 0, 0};
        case (pal)
            PAL_RAINBOW: begin
                if (v <= 63) begin
                    ch[2] = clip8(4 * v);
                end else if (v <= 127) begin
                    u = 4 * v - 255;
                    ch[1] = clip8(u); ch[2] = clip8((65025 - 105 * u) / 255);
                end else if (v <= 191) begin
                    u = 4 * v - 510;
                    ch[0] = clip8(u); ch[1] = 255; ch[2] = clip8(150 * (255 - u) / 255);
                end else begin
                    u = 4 * v - 765;
                    ch[0] = 255; ch[1] = clip8(255 - u);
                end
            end
            PAL_LBLUE: begin
                if (v <= 84) begin
                    ch[2] = clip8(450 * v / 255);
                end else if (v <= 168) begin
                    u = 300 * v - 25245;
                    ch[1] = clip8(206 * u / 25500); ch[2] = clip8(150 + 105 * u / 25500);
                end else begin
                    u = 300 * v - 50490;
                    ch[0] = clip8(u / 100); ch[1] = clip8(206 + 49 * u / 25500);
                    ch[2] = 255;
                end
            end
            PAL_GRAY: ch = '{v, v, v};
            PAL_COOLHOT: begin
                if (v <= 63) begin
                    ch[0] = clip8(400 * v / 255); ch[2] = clip8(600 * v / 255);
                end else if (v <= 127) begin
                    u = 4 * v - 255;
                    ch[0] = clip8(100 + 155 * u / 255); ch[2] = clip8(150 * (255 - u) / 255);
                end else if (v <= 191) begin
                    u = 4 * v - 510;
                    ch[0] = 255; ch[1] = clip8(200 * u / 255);
                end else begin
                    u = 4 * v - 765;
                    ch[0] = 255; ch[1] = clip8(200 + 55 * u / 255); ch[2] = clip8(u);
                end
            end
            PAL_PHOSPHOR: begin
                if (v <= 0) begin
                    ch = stop_rgb[0];
                end else if (v >= 255) begin
                    ch = stop_rgb[4];
                end else begin
                    seg = 0;
                    while (seg < 3 && 100 * v > 255 * stop_at[seg + 1]) seg++;
                    num = 100 * v - 255 * stop_at[seg];
                    den = 255 * (stop_at[seg + 1] - stop_at[seg]);
                    for (int j = 0; j < 3; j++)
                        ch[j] = blend(stop_rgb[seg][j], stop_rgb[seg + 1][j], num, den);
                end
            end
            default: begin
                // lcd: dark half fades base to 0x38, bright half 0x38 to black
                if (v <= 114) begin
                    t = ratio_pow(4 * v, 459, 3, 4);
                    for (int j = 0; j < 3; j++)
                        ch[j] = blend(lcd_base[j], 8'h38, t, UNIT);
                end else begin
                    t = ratio_pow(4 * v - 459, 561, 7, 10);
                    for (int j = 0; j < 3; j++) ch[j] = blend(8'h38, 0, t, UNIT);
                end
            end
        endcase
        c.red   = ch[0][7:0];
        c.green = ch[1][7:0];
        c.blue  = ch[2][7:0];
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_color exp_c;
        if (!i_rst_n) begin
            sens_q     <= 8'd100;
            contrast_q <= 9'd100;
            palette_q  <= PAL_RAINBOW;
            color_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SENS:     sens_q     <= i_cfg_data[7:0];
                    CFG_CONTRAST: contrast_q <= i_cfg_data;
                    CFG_PALETTE:  palette_q  <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_px_valid && !i_px_stall)
                color_q.push_back(map_pixel(i_px_intensity, sens_q, contrast_q, palette_q));
            if (i_col_valid && !i_col_stall) begin
                if (color_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: color word %0h/%0h/%0h with nothing expected",
                                 i_col_red, i_col_green, i_col_blue);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_c = color_q.pop_front();
                    if (exp_c != {i_col_red, i_col_green, i_col_blue}) begin
                        if (o_fail_count < 10)
                            $display("ERROR: color exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                     exp_c.red, exp_c.green, exp_c.blue,
                                     i_col_red, i_col_green, i_col_blue);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = color_q.size();

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives pixel intensities and register writes into the intensity mapper
// under random bursts and output stalls; the checker beside it scores colors.
// ----------------------------------------------------------------------------
module tb;
    import igfc_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_intensity = 8'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_red, o_green, o_blue;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = CFG_SENS;
    logic [8:0] i_cfg_data = 9'd0;

    int fail_count;
    int pending;
    int burst_left = 0;
    int words_sent = 0;
    int phases_run = 0;
    bit hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    intensity_gamma_false_color_map u_dut (.*);

    igfc_checker u_chk (
        .i_clk, .i_rst_n,
        .i_px_valid(i_valid), .i_px_stall(o_stall), .i_px_intensity(i_intensity),
        .i_col_valid(o_valid), .i_col_stall(i_stall),
        .i_col_red(o_red), .i_col_green(o_green), .i_col_blue(o_blue),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: stall patterns, plus a long hold-off on request
    initial begin
        int hold_left, mode, mode_left, tick;
        hold_left = 0; mode = 0; mode_left = 0; tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
                i_stall  <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 2) == 0);
                    default: i_stall <= (tick % 5 == 0);
                endcase
            end
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [7:0] sens, logic [8:0] ctr, logic [2:0] pal);
        cfg_write(CFG_SENS, {1'b0, sens});
        cfg_write(CFG_CONTRAST, ctr);
        cfg_write(CFG_PALETTE, {6'd0, pal});
    endtask

    // one pixel word, with bursts and random gaps between them
    task automatic push_pixel(logic [7:0] val, bit steady);
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = steady ? 100000 : $urandom_range(1, 30);
        end
        i_valid     <= 1'b1;
        i_intensity <= val;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        words_sent++;
    endtask

    // hold the sender until every color word is back
    task automatic drain();
        i_valid    <= 1'b0;
        burst_left  = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (90) @(posedge i_clk);
        phases_run++;
    endtask

    function automatic logic [7:0] pick_intensity();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] sens;
        logic [8:0] ctr;
        bit steady;
        logic [7:0] probe_px [8];
        probe_px = '{8'd128, 8'd255, 8'd200, 8'd64, 8'd180, 8'd0, 8'd96, 8'd240};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each palette code, then offset and gamma extremes
        for (int p = 0; p < 8; p++) begin
            set_regs(8'd100, 9'd100, 3'(p));
            push_pixel(probe_px[p], 1'b0);
            push_pixel(8'd255 - probe_px[p], 1'b0);
            drain();
        end
        set_regs(8'd0, 9'd0, PAL_GRAY);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd80, 1'b0);
        drain();
        set_regs(8'd255, 9'd511, PAL_PHOSPHOR);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd1, 1'b0);
        drain();
        set_regs(8'd200, 9'd300, PAL_LBLUE);
        push_pixel(8'd128, 1'b0);
        push_pixel(8'd255, 1'b0);
        drain();

        // random phases with fresh register settings
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 3))
                0:       sens = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd255;
                1:       sens = 8'd100;
                default: sens = 8'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       ctr = ($urandom_range(0, 1) != 0) ? 9'd0 : 9'd511;
                1:       ctr = 9'($urandom_range(0, 300));
                default: ctr = 9'($urandom);
            endcase
            set_regs(sens, ctr, 3'($urandom));
            steady = (ph % 4 == 1);
            if (ph == 3) hold_req = 1'b1;
            repeat (60) push_pixel(pick_intensity(), steady);
            drain();
        end

        $display("Sent %0d pixel words over %0d register phases, all palette codes,",
                 words_sent, phases_run);
        $display("offset and gamma extremes, bursty input and stalled output.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
design/igfc_pkg.sv
design/igfc_powq.sv
design/igfc_palette.sv
design/intensity_gamma_false_color_map.sv
sim/igfc_checker.sv
sim/tb.sv
